FILE: src/pose_select_pd_joint_control_unit_assert.svh
// Assertion macros for the pose-select PD joint control unit.
`ifndef POSE_SELECT_PD_JOINT_CONTROL_UNIT_ASSERT_SVH
`define POSE_SELECT_PD_JOINT_CONTROL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define PDJ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdj assertion failed");
// Next-cycle implication, disabled during reset.
`define PDJ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdj assertion failed");
`else
`define PDJ_ASSERT_IMP(label, clk, rst, ante, cons)
`define PDJ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/pdj_pkg.sv
// Shared types, widths, codes and the pose table of the joint control unit.
`default_nettype none

package pdj_pkg;

  localparam int JIDX_W      = 4;
  localparam int ANGLE_W     = 16;
  localparam int ERR_W       = ANGLE_W + 1;
  localparam int MODE_W      = 2;
  localparam int TS_W        = 24;
  localparam int TS_FRAC     = 24;
  localparam int INV_W       = 16;
  localparam int GAIN_W      = 24;
  localparam int GAIN_FRAC   = 8;
  localparam int CMD_W       = 32;
  localparam int PROD_W      = ERR_W + TS_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [CMD_W-1:0] CMD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 32'sh8000_0000;

  localparam logic [TS_W-1:0]   TIME_STEP_RESET  = 24'd16777;
  localparam logic [INV_W-1:0]  INV_STEP_RESET   = 16'd1000;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 24'd38400;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 24'd3840;

  typedef enum logic [MODE_W-1:0] {
    MODE_EFFORT   = 2'd0,
    MODE_POSITION = 2'd1,
    MODE_VELOCITY = 2'd2
  } pdj_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_TIME_STEP     = 3'd1,
    REG_INV_TIME_STEP = 3'd2,
    REG_PROP_GAIN     = 3'd3,
    REG_DERIV_GAIN    = 3'd4
  } pdj_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TS_W-1:0]   time_step;
    logic [INV_W-1:0]  inv_time_step;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
  } pdj_cfg_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [JIDX_W-1:0]         joint;
    logic                      in_range;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ERR_W-1:0]   err;
    logic signed [PROD_W-1:0]  prod;
  } pdj_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pdj_qstat_t;

  localparam logic signed [ANGLE_W-1:0] POSE_LYING [0:2] =
    '{16'sd0, 16'sd6877, -16'sd10251};
  localparam logic signed [ANGLE_W-1:0] POSE_STANDING [0:2] =
    '{16'sd0, 16'sd4318, -16'sd6877};

  // Target angle of a joint; the pose repeats every three joints.
  function automatic logic signed [ANGLE_W-1:0] pose_angle(input logic lying,
                                                           input logic [JIDX_W-1:0] joint);
    logic [1:0] k;
    case (joint)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: k = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       k = 2'd1;
      default:                              k = 2'd2;
    endcase
    return lying ? POSE_LYING[k] : POSE_STANDING[k];
  endfunction

endpackage

`default_nettype wire

FILE: src/pdj_cfg_if.sv
// Register write channel of the joint control unit.
`default_nettype none

interface pdj_cfg_if;
  import pdj_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: src/pdj_in_if.sv
// Joint sample channel of the joint control unit.
`default_nettype none

interface pdj_in_if;
  import pdj_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [JIDX_W-1:0]         joint_index;
  logic signed [ANGLE_W-1:0] joint_angle;
  logic                      lie_button;
  logic                      stand_button;

  modport source (output valid, output joint_index, output joint_angle,
                  output lie_button, output stand_button, input ready);
  modport sink   (input valid, input joint_index, input joint_angle,
                  input lie_button, input stand_button, output ready);
endinterface

`default_nettype wire

FILE: src/pdj_out_if.sv
// Joint command channel of the joint control unit.
`default_nettype none

interface pdj_out_if;
  import pdj_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [JIDX_W-1:0]       out_joint_index;
  logic signed [CMD_W-1:0] command;
  logic                    saturated;

  modport source (output valid, output out_joint_index, output command,
                  output saturated, input ready);
  modport sink   (input valid, input out_joint_index, input command,
                  input saturated, output ready);
endinterface

`default_nettype wire

FILE: src/pdj_front.sv
// Front end: accepts samples, tracks the pose buttons, forms the tracking error product.
`default_nettype none

module pdj_front #(
  parameter int JOINT_COUNT = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  pdj_in_if.sink                samples,
  input  logic [pdj_pkg::TS_W-1:0] time_step,
  input  pdj_pkg::pdj_qstat_t   qstat,
  output logic                  push,
  output pdj_pkg::pdj_item_t    push_item
);
  import pdj_pkg::*;

  logic                      lie_flag;
  logic                      lie_flag_next;
  logic                      prev_lie;
  logic                      prev_stand;
  logic                      first_joint;
  logic signed [ANGLE_W-1:0] target;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W:0]    prod_full;

  assign samples.ready = !qstat.full;
  assign push          = samples.valid && samples.ready;
  assign first_joint   = (samples.joint_index == '0);

  // Lie first, stand second: a stand edge wins when both rise together.
  always_comb begin
    lie_flag_next = lie_flag;
    if (first_joint) begin
      if (samples.lie_button && !prev_lie) begin
        lie_flag_next = 1'b1;
      end
      if (samples.stand_button && !prev_stand) begin
        lie_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lie_flag   <= 1'b0;
      prev_lie   <= 1'b0;
      prev_stand <= 1'b0;
    end else if (push && first_joint) begin
      lie_flag   <= lie_flag_next;
      prev_lie   <= samples.lie_button;
      prev_stand <= samples.stand_button;
    end
  end

  assign target    = pose_angle(lie_flag_next, samples.joint_index);
  assign err       = ERR_W'(target) - ERR_W'(samples.joint_angle);
  assign prod_full = err * $signed({1'b0, time_step});

  always_comb begin
    push_item.joint    = samples.joint_index;
    push_item.in_range = (32'(samples.joint_index) < JOINT_COUNT);
    push_item.angle    = samples.joint_angle;
    push_item.err      = err;
    push_item.prod     = prod_full[PROD_W-1:0];
  end

endmodule

`default_nettype wire

FILE: src/pdj_queue.sv
// Short FIFO that decouples the front end from the arithmetic back end.
`default_nettype none

module pdj_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pdj_pkg::pdj_item_t   push_item,
  input  logic                 pop,
  output pdj_pkg::pdj_item_t   head,
  output pdj_pkg::pdj_qstat_t  qstat
);
  import pdj_pkg::*;

  pdj_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head        = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: src/pdj_back.sv
// Back end: per-joint reference update, velocity estimate and PD effort pipeline.
`default_nettype none

module pdj_back #(
  parameter int JOINT_COUNT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  pdj_pkg::pdj_cfg_t   cfg,
  input  pdj_pkg::pdj_qstat_t qstat,
  input  pdj_pkg::pdj_item_t  head,
  output logic                pop,
  pdj_out_if.source           commands
);
  import pdj_pkg::*;

  localparam int IDX_W   = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int HI_W    = PROD_W - TS_FRAC;
  localparam int POS_W   = ANGLE_W + 3;
  localparam int RSUM_W  = CMD_W + 2;
  localparam int EP_W    = CMD_W + 1;
  localparam int DQ_W    = ERR_W + INV_W;
  localparam int ED_W    = DQ_W + 1;
  localparam int LO_P_W  = EP_W / 2;
  localparam int LO_D_W  = ED_W / 2;
  localparam int SUM_W   = GAIN_W + ED_W + 2;
  localparam int RND_W   = SUM_W - GAIN_FRAC + 1;
  localparam int STAGES  = 6;

  typedef struct packed {
    logic [JIDX_W-1:0]       joint;
    logic                    in_range;
    logic signed [CMD_W-1:0] simple;
  } tag_t;

  // Per-joint state
  logic [JOINT_COUNT-1:0]    seen;
  logic signed [CMD_W-1:0]   ref_arr  [JOINT_COUNT];
  logic signed [ANGLE_W-1:0] prev_arr [JOINT_COUNT];

  // Stage one, read from the queue head
  logic                      adv;
  logic [IDX_W-1:0]          jidx;
  logic signed [ANGLE_W-1:0] hq;
  logic signed [ERR_W-1:0]   herr;
  logic signed [PROD_W-1:0]  hprod;
  logic signed [HI_W-1:0]    prod_hi;
  logic                      round_bit;
  logic signed [CMD_W-1:0]   ref_old;
  logic signed [ANGLE_W-1:0] prev_old;
  logic signed [RSUM_W-1:0]  rsum;
  logic signed [CMD_W-1:0]   ref_new;
  logic signed [POS_W-1:0]   pos;
  logic signed [ERR_W-1:0]   dq_diff;
  tag_t                      tag_in;

  // Pipeline registers
  logic [STAGES-1:0]         vld;
  tag_t                      tag [STAGES];
  logic signed [ANGLE_W-1:0] q1;
  logic signed [CMD_W-1:0]   ref1;
  logic signed [ERR_W-1:0]   dqd1;
  logic signed [ERR_W-1:0]   err1;
  logic signed [ERR_W-1:0]   err2;
  logic signed [EP_W-1:0]    ep2;
  logic signed [DQ_W-1:0]    dq2;
  logic signed [DQ_W:0]      dq_full;
  logic signed [EP_W-1:0]    ep3;
  logic signed [ED_W-1:0]    ed3;
  logic [GAIN_W+LO_P_W-1:0]  pg_lo4;
  logic signed [GAIN_W+EP_W-LO_P_W:0] pg_hi4;
  logic [GAIN_W+LO_D_W-1:0]  dg_lo4;
  logic signed [GAIN_W+ED_W-LO_D_W:0] dg_hi4;
  logic signed [SUM_W-1:0]   sp5;
  logic signed [SUM_W-1:0]   sd5;
  logic signed [SUM_W-1:0]   sum6;

  // Final stage
  logic signed [RND_W-1:0]   rnd;
  logic signed [CMD_W-1:0]   eff;
  logic                      eff_sat;
  logic                      out_valid;
  logic [JIDX_W-1:0]         out_joint;
  logic signed [CMD_W-1:0]   out_cmd;
  logic                      out_sat;

  // The whole pipeline holds while a command waits on the output.
  assign adv = !out_valid || commands.ready;
  assign pop = adv && !qstat.empty;

  assign jidx      = IDX_W'(head.joint);
  assign hq        = head.angle;
  assign herr      = head.err;
  assign hprod     = head.prod;
  assign prod_hi   = hprod[PROD_W-1:TS_FRAC];
  assign round_bit = hprod[TS_FRAC-1];

  // A joint's first sample stands in for its stored reference and angle.
  assign ref_old  = seen[jidx] ? ref_arr[jidx]  : CMD_W'(hq);
  assign prev_old = seen[jidx] ? prev_arr[jidx] : hq;

  assign rsum    = RSUM_W'(ref_old) + RSUM_W'(prod_hi) + RSUM_W'(round_bit);
  assign pos     = POS_W'(hq) + POS_W'(prod_hi) + POS_W'(round_bit);
  assign dq_diff = ERR_W'(hq) - ERR_W'(prev_old);

  always_comb begin
    if (rsum > RSUM_W'(CMD_MAX)) begin
      ref_new = CMD_MAX;
    end else if (rsum < RSUM_W'(CMD_MIN)) begin
      ref_new = CMD_MIN;
    end else begin
      ref_new = rsum[CMD_W-1:0];
    end
  end

  always_comb begin
    tag_in.joint    = head.joint;
    tag_in.in_range = head.in_range;
    case (cfg.mode)
      MODE_POSITION: tag_in.simple = CMD_W'(pos);
      MODE_VELOCITY: tag_in.simple = CMD_W'(herr);
      default:       tag_in.simple = '0;
    endcase
    if (!head.in_range) begin
      tag_in.simple = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (pop && head.in_range) begin
      seen[jidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.in_range) begin
      ref_arr[jidx]  <= ref_new;
      prev_arr[jidx] <= hq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[STAGES-2:0], pop};
      out_valid <= vld[STAGES-1];
    end
  end

  assign dq_full = dqd1 * $signed({1'b0, cfg.inv_time_step});

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= tag_in;
      for (int i = 1; i < STAGES; i++) begin
        tag[i] <= tag[i-1];
      end
      q1     <= hq;
      ref1   <= ref_new;
      dqd1   <= dq_diff;
      err1   <= herr;
      err2   <= err1;
      ep2    <= EP_W'(ref1) - EP_W'(q1);
      dq2    <= dq_full[DQ_W-1:0];
      ep3    <= ep2;
      ed3    <= ED_W'(err2) - ED_W'(dq2);
      // Split each gain product into two narrow partial products.
      pg_lo4 <= cfg.prop_gain * ep3[LO_P_W-1:0];
      pg_hi4 <= $signed({1'b0, cfg.prop_gain}) * $signed(ep3[EP_W-1:LO_P_W]);
      dg_lo4 <= cfg.deriv_gain * ed3[LO_D_W-1:0];
      dg_hi4 <= $signed({1'b0, cfg.deriv_gain}) * $signed(ed3[ED_W-1:LO_D_W]);
      sp5    <= (SUM_W'(pg_hi4) <<< LO_P_W) + SUM_W'(pg_lo4);
      sd5    <= (SUM_W'(dg_hi4) <<< LO_D_W) + SUM_W'(dg_lo4);
      sum6   <= sp5 + sd5;
    end
  end

  // Round the Q.8 effort to an integer, half up, then clip to 32 bits.
  assign rnd = RND_W'($signed(sum6[SUM_W-1:GAIN_FRAC])) + RND_W'(sum6[GAIN_FRAC-1]);

  always_comb begin
    eff     = rnd[CMD_W-1:0];
    eff_sat = 1'b0;
    if (rnd > RND_W'(CMD_MAX)) begin
      eff     = CMD_MAX;
      eff_sat = 1'b1;
    end else if (rnd < RND_W'(CMD_MIN)) begin
      eff     = CMD_MIN;
      eff_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_joint <= tag[STAGES-1].joint;
      if (tag[STAGES-1].in_range && cfg.mode == MODE_EFFORT) begin
        out_cmd <= eff;
        out_sat <= eff_sat;
      end else begin
        out_cmd <= tag[STAGES-1].simple;
        out_sat <= 1'b0;
      end
    end
  end

  assign commands.valid           = out_valid;
  assign commands.out_joint_index = out_joint;
  assign commands.command         = out_cmd;
  assign commands.saturated       = out_sat;

endmodule

`default_nettype wire

FILE: src/pose_select_pd_joint_control_unit.sv
// Top level of the pose-select PD joint control unit.
//
//  channel    direction  handshake                  payload
//  cfg        in         cfg.valid / cfg.ready      reg_index, wr_data
//  samples    in         samples.valid / .ready     joint_index, joint_angle, buttons
//  commands   out        commands.valid / .ready    out_joint_index, command, saturated
//
// One sample is taken per cycle while the queue has room; its command then passes through the back end.
// The rate is set by the six-stage back-end pipeline, which advances one sample per cycle unless a command waits.
// A four-entry queue sits between front and back; samples are refused only when it is full.
// A waiting command freezes the back end, the queue keeps taking samples until it fills.
// rst is synchronous: it clears pose state, joint-seen bits, queue and pipeline valids.
// Register writes are always taken (ready held high).
`default_nettype none
`include "pose_select_pd_joint_control_unit_assert.svh"

module pose_select_pd_joint_control_unit #(
  parameter int JOINT_COUNT = 12
) (
  input  logic      clk,
  input  logic      rst,
  pdj_cfg_if.sink   cfg,
  pdj_in_if.sink    samples,
  pdj_out_if.source commands
);
  import pdj_pkg::*;

  pdj_cfg_t   cfg_regs;
  logic       push;
  logic       pop;
  pdj_item_t  push_item;
  pdj_item_t  head;
  pdj_qstat_t qstat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode          <= MODE_EFFORT;
      cfg_regs.time_step     <= TIME_STEP_RESET;
      cfg_regs.inv_time_step <= INV_STEP_RESET;
      cfg_regs.prop_gain     <= PROP_GAIN_RESET;
      cfg_regs.deriv_gain    <= DERIV_GAIN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_MODE:          cfg_regs.mode          <= cfg.wr_data[MODE_W-1:0];
        REG_TIME_STEP:     cfg_regs.time_step     <= cfg.wr_data[TS_W-1:0];
        REG_INV_TIME_STEP: cfg_regs.inv_time_step <= cfg.wr_data[INV_W-1:0];
        REG_PROP_GAIN:     cfg_regs.prop_gain     <= cfg.wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg_regs.deriv_gain    <= cfg.wr_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pdj_front #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .time_step (cfg_regs.time_step),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  pdj_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  pdj_back #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .commands (commands)
  );

  `PDJ_ASSERT_NXT(a_push_fills_queue, clk, rst, push && !pop, !qstat.empty)
  `PDJ_ASSERT_IMP(a_pop_has_item, clk, rst, pop, !qstat.empty)
  `PDJ_ASSERT_IMP(a_sat_only_clipped_effort, clk, rst, commands.valid && commands.saturated, cfg_regs.mode == MODE_EFFORT && (commands.command == CMD_MAX || commands.command == CMD_MIN))
  `PDJ_ASSERT_IMP(a_bad_joint_zero, clk, rst, commands.valid && (32'(commands.out_joint_index) >= JOINT_COUNT), commands.command == '0 && !commands.saturated)

endmodule

`default_nettype wire
